>>> hdl/rv32im_instruction_decoder_macros.svh
// Assertion macros shared by the decoder modules
`ifndef RV32IM_INSTRUCTION_DECODER_MACROS_SVH
`define RV32IM_INSTRUCTION_DECODER_MACROS_SVH
// implication checked every cycle outside reset
`define RVD_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// implication checked in the following cycle
`define RVD_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

>>> hdl/rvd_pkg.sv
// Package: decoder types, mnemonic codes and match table
`timescale 1ns / 1ps
package rvd_pkg;
   localparam int unsigned NumPatterns = 49;

   typedef enum logic [6:0] {
      MN_BEQ = 7'd0, MN_BNE = 7'd1, MN_BLT = 7'd2, MN_BGE = 7'd3, MN_BLTU = 7'd4,
      MN_BGEU = 7'd5, MN_JALR = 7'd6, MN_JAL = 7'd7, MN_LUI = 7'd8, MN_AUIPC = 7'd9,
      MN_ADDI = 7'd10, MN_SLLI = 7'd11, MN_SLTI = 7'd12, MN_SLTIU = 7'd13,
      MN_XORI = 7'd14, MN_SRLI = 7'd15, MN_SRAI = 7'd16, MN_ORI = 7'd17,
      MN_ANDI = 7'd18, MN_ADD = 7'd19, MN_SUB = 7'd20, MN_SLL = 7'd21,
      MN_SLT = 7'd22, MN_SLTU = 7'd23, MN_XOR = 7'd24, MN_SRL = 7'd25,
      MN_SRA = 7'd26, MN_OR = 7'd27, MN_AND = 7'd28, MN_LB = 7'd29, MN_LH = 7'd30,
      MN_LW = 7'd31, MN_LBU = 7'd32, MN_LHU = 7'd33, MN_SB = 7'd34, MN_SH = 7'd35,
      MN_SW = 7'd36, MN_FENCE = 7'd37, MN_FENCEI = 7'd38, MN_ECALL = 7'd39,
      MN_EBREAK = 7'd40, MN_MUL = 7'd41, MN_MULH = 7'd42, MN_MULHSU = 7'd43,
      MN_MULHU = 7'd44, MN_DIV = 7'd45, MN_DIVU = 7'd46, MN_REM = 7'd47,
      MN_REMU = 7'd48, MN_NOP = 7'd49, MN_LI = 7'd50, MN_MV = 7'd51,
      MN_BEQZ = 7'd52, MN_BNEZ = 7'd53, MN_BGEZ = 7'd54, MN_BLEZ = 7'd55,
      MN_BLTZ = 7'd56, MN_BGTZ = 7'd57, MN_J = 7'd58, MN_RET = 7'd59,
      MN_JR = 7'd60, MN_SEQZ = 7'd61, MN_SNEZ = 7'd62, MN_SGTZ = 7'd63,
      MN_NEG = 7'd64, MN_NOT = 7'd65
   } mnemonic_type;

   // classified request passed from front to back
   typedef struct packed {
      logic         recognized;
      mnemonic_type base_id;
      logic [31:0]  word;
      logic [31:0]  pc;
   } classified_type;

   typedef struct packed {
      logic [31:0] mask;
      logic [31:0] match;
   } pattern_type;

   function automatic pattern_type pattern_at(input logic [5:0] k);
      pattern_type p;
      p = '{mask: 32'h0000_707f, match: 32'h0};
      unique case (k)
         6'd0: p.match = 32'h63;
         6'd1: p.match = 32'h1063;
         6'd2: p.match = 32'h4063;
         6'd3: p.match = 32'h5063;
         6'd4: p.match = 32'h6063;
         6'd5: p.match = 32'h7063;
         6'd6: p.match = 32'h67;
         6'd7: p = '{32'h7f, 32'h6f};
         6'd8: p = '{32'h7f, 32'h37};
         6'd9: p = '{32'h7f, 32'h17};
         6'd10: p.match = 32'h13;
         6'd11: p = '{32'hfe00707f, 32'h1013};
         6'd12: p.match = 32'h2013;
         6'd13: p.match = 32'h3013;
         6'd14: p.match = 32'h4013;
         6'd15: p = '{32'hfe00707f, 32'h5013};
         6'd16: p = '{32'hfe00707f, 32'h40005013};
         6'd17: p.match = 32'h6013;
         6'd18: p.match = 32'h7013;
         6'd19: p = '{32'hfe00707f, 32'h33};
         6'd20: p = '{32'hfe00707f, 32'h40000033};
         6'd21: p = '{32'hfe00707f, 32'h1033};
         6'd22: p = '{32'hfe00707f, 32'h2033};
         6'd23: p = '{32'hfe00707f, 32'h3033};
         6'd24: p = '{32'hfe00707f, 32'h4033};
         6'd25: p = '{32'hfe00707f, 32'h5033};
         6'd26: p = '{32'hfe00707f, 32'h40005033};
         6'd27: p = '{32'hfe00707f, 32'h6033};
         6'd28: p = '{32'hfe00707f, 32'h7033};
         6'd29: p.match = 32'h3;
         6'd30: p.match = 32'h1003;
         6'd31: p.match = 32'h2003;
         6'd32: p.match = 32'h4003;
         6'd33: p.match = 32'h5003;
         6'd34: p.match = 32'h23;
         6'd35: p.match = 32'h1023;
         6'd36: p.match = 32'h2023;
         6'd37: p.match = 32'hf;
         6'd38: p.match = 32'h100f;
         6'd39: p = '{32'hffffffff, 32'h73};
         6'd40: p = '{32'hffffffff, 32'h100073};
         6'd41: p = '{32'hfe00707f, 32'h2000033};
         6'd42: p = '{32'hfe00707f, 32'h2001033};
         6'd43: p = '{32'hfe00707f, 32'h2002033};
         6'd44: p = '{32'hfe00707f, 32'h2003033};
         6'd45: p = '{32'hfe00707f, 32'h2004033};
         6'd46: p = '{32'hfe00707f, 32'h2005033};
         6'd47: p = '{32'hfe00707f, 32'h2006033};
         6'd48: p = '{32'hfe00707f, 32'h2007033};
         default: p = '{32'hffffffff, 32'h0};
      endcase
      return p;
   endfunction
endpackage

>>> hdl/rvd_front.sv
// Front end: takes requests and matches the word against the encoding table
`timescale 1ns / 1ps
module rvd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [31:0]             req_instr_word,
   input  logic [31:0]             req_pc,
   output logic                    cls_valid,
   input  logic                    cls_stall,
   output rvd_pkg::classified_type cls_data
);
   logic                    valid_ff, valid_in;
   rvd_pkg::classified_type data_ff, data_in;
   logic [48:0]             hit;
   logic                    take;

   // first hit wins, table order
   always_comb begin
      rvd_pkg::pattern_type p;
      for (int k = 0; k < rvd_pkg::NumPatterns; k++) begin
         p = rvd_pkg::pattern_at(6'(k));
         hit[k] = (req_instr_word & p.mask) == p.match;
      end
   end

   always_comb begin
      data_in.recognized = |hit;
      data_in.base_id    = rvd_pkg::MN_BEQ;
      data_in.word       = req_instr_word;
      data_in.pc         = req_pc;
      for (int k = rvd_pkg::NumPatterns - 1; k >= 0; k--) begin
         if (hit[k]) data_in.base_id = rvd_pkg::mnemonic_type'(7'(k));
      end
   end

   assign req_stall = valid_ff && cls_stall;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take ? 1'b1 : (valid_ff && cls_stall);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (take) data_ff <= data_in;
   end

   assign cls_valid = valid_ff;
   assign cls_data  = data_ff;
endmodule

>>> hdl/rvd_queue.sv
// Two-entry queue between front and back end
`timescale 1ns / 1ps
`include "rv32im_instruction_decoder_macros.svh"
module rvd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  rvd_pkg::classified_type in_data,
   output logic                    out_valid,
   input  logic                    out_stall,
   output rvd_pkg::classified_type out_data
);
   rvd_pkg::classified_type mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = count_ff == 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = mem_ff[rptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign wptr_in   = wptr_ff ^ push;
   assign rptr_in   = rptr_ff ^ pop;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) mem_ff[wptr_ff] <= in_data;
   end

   `RVD_ASSERT_IMP(a_q_bound, clock, reset, 1'b1, count_ff <= 2'd2, "queue overfilled")
   `RVD_ASSERT_NEXT(a_q_full, clock, reset, push && !pop && count_ff == 2'd1,
      count_ff == 2'd2, "queue count lost a push")
   `RVD_ASSERT_IMP(a_q_ptr, clock, reset, count_ff == 2'd0 || count_ff == 2'd2,
      wptr_ff == rptr_ff, "queue pointers disagree with count")
endmodule

>>> hdl/rvd_back.sv
// Back end: picks aliases, forms operands and immediate, holds the response
`timescale 1ns / 1ps
`include "rv32im_instruction_decoder_macros.svh"
module rvd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cls_valid,
   output logic                    cls_stall,
   input  rvd_pkg::classified_type cls_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [6:0]              rsp_mnemonic_id,
   output logic [4:0]              rsp_src_reg_a,
   output logic [4:0]              rsp_src_reg_b,
   output logic [4:0]              rsp_dest_reg,
   output logic                    rsp_uses_src_a,
   output logic                    rsp_uses_src_b,
   output logic                    rsp_uses_dest,
   output logic signed [31:0]      rsp_immediate,
   output logic                    rsp_recognized
);
   logic [31:0] w, pc, ii, is, ib, ij, tb, imm;
   logic [4:0]  rs1, rs2, rd;
   logic        ua, ub, ud, ok, take;
   rvd_pkg::mnemonic_type id;

   logic        valid_ff, valid_in;
   logic [6:0]  id_ff;
   logic [4:0]  ra_ff, rb_ff, rd_ff;
   logic        ua_ff, ub_ff, ud_ff, ok_ff;
   logic [31:0] imm_ff;

   assign w   = cls_data.word;
   assign pc  = cls_data.pc;
   assign rs1 = w[19:15];
   assign rs2 = w[24:20];
   assign rd  = w[11:7];
   assign ii  = {{20{w[31]}}, w[31:20]};
   assign is  = {{20{w[31]}}, w[31:25], w[11:7]};
   assign ib  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
   assign ij  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
   assign tb  = pc + ib;

   always_comb begin
      id  = cls_data.base_id;
      ua  = 1'b1;
      ub  = 1'b1;
      ud  = 1'b1;
      imm = '0;
      ok  = cls_data.recognized;
      unique case (cls_data.base_id)
         rvd_pkg::MN_BEQ, rvd_pkg::MN_BNE, rvd_pkg::MN_BLT, rvd_pkg::MN_BGE,
         rvd_pkg::MN_BLTU, rvd_pkg::MN_BGEU: begin
            ud  = 1'b0;
            imm = tb;
            if (cls_data.base_id == rvd_pkg::MN_BEQ && rs2 == 5'd0) begin
               id = rvd_pkg::MN_BEQZ; ub = 1'b0;
            end else if (cls_data.base_id == rvd_pkg::MN_BNE && rs2 == 5'd0) begin
               id = rvd_pkg::MN_BNEZ; ub = 1'b0;
            end else if (cls_data.base_id == rvd_pkg::MN_BLT) begin
               if (rs2 == 5'd0) begin
                  id = rvd_pkg::MN_BLTZ; ub = 1'b0;
               end else if (rs1 == 5'd0) begin
                  id = rvd_pkg::MN_BGTZ; ua = 1'b0;
               end
            end else if (cls_data.base_id == rvd_pkg::MN_BGE) begin
               if (rs2 == 5'd0) begin
                  id = rvd_pkg::MN_BGEZ; ub = 1'b0;
               end else if (rs1 == 5'd0) begin
                  id = rvd_pkg::MN_BLEZ; ua = 1'b0;
               end
            end
         end
         rvd_pkg::MN_JALR: begin
            ub = 1'b0;
            ud = 1'b0;
            priority if (ii == 32'd0 && rd == 5'd0 && rs1 == 5'd1) begin
               id = rvd_pkg::MN_RET; ua = 1'b0;
            end else if (ii == 32'd0 && rd == 5'd1) begin
               id = rvd_pkg::MN_JALR;
            end else if (ii == 32'd0 && rd == 5'd0) begin
               id = rvd_pkg::MN_JR;
            end else if (rd == rs1) begin
               imm = ii;
            end else begin
               imm = ii; ud = 1'b1;
            end
         end
         rvd_pkg::MN_JAL: begin
            ua = 1'b0; ub = 1'b0;
            imm = pc + ij;
            if (rd == 5'd0) begin
               id = rvd_pkg::MN_J; ud = 1'b0;
            end
         end
         rvd_pkg::MN_LUI, rvd_pkg::MN_AUIPC: begin
            ua = 1'b0; ub = 1'b0;
            imm = {12'd0, w[31:12]};
         end
         rvd_pkg::MN_ADDI: begin
            ub = 1'b0;
            if (rs1 == 5'd0) begin
               ua = 1'b0;
               if (rd == 5'd0 && ii == 32'd0) begin
                  id = rvd_pkg::MN_NOP; ud = 1'b0;
               end else begin
                  id = rvd_pkg::MN_LI; imm = ii;
               end
            end else if (ii == 32'd0) id = rvd_pkg::MN_MV;
            else imm = ii;
         end
         rvd_pkg::MN_SLLI, rvd_pkg::MN_SRLI, rvd_pkg::MN_SRAI: begin
            ub = 1'b0;
            imm = {27'd0, rs2};
         end
         rvd_pkg::MN_SLTIU: begin
            ub = 1'b0;
            if (ii == 32'd1) id = rvd_pkg::MN_SEQZ;
            else imm = ii;
         end
         rvd_pkg::MN_XORI: begin
            ub = 1'b0;
            if (ii == 32'hffff_ffff) id = rvd_pkg::MN_NOT;
            else imm = ii;
         end
         rvd_pkg::MN_SLTI, rvd_pkg::MN_ORI, rvd_pkg::MN_ANDI, rvd_pkg::MN_LB,
         rvd_pkg::MN_LH, rvd_pkg::MN_LW, rvd_pkg::MN_LBU, rvd_pkg::MN_LHU: begin
            ub = 1'b0;
            imm = ii;
         end
         rvd_pkg::MN_SUB: if (rs1 == 5'd0) begin
            id = rvd_pkg::MN_NEG; ua = 1'b0;
         end
         rvd_pkg::MN_SLT: if (rs1 == 5'd0) begin
            id = rvd_pkg::MN_SGTZ; ua = 1'b0;
         end
         rvd_pkg::MN_SLTU: if (rs1 == 5'd0) begin
            id = rvd_pkg::MN_SNEZ; ua = 1'b0;
         end
         rvd_pkg::MN_SB, rvd_pkg::MN_SH, rvd_pkg::MN_SW: begin
            ud = 1'b0;
            imm = is;
         end
         rvd_pkg::MN_FENCE, rvd_pkg::MN_FENCEI, rvd_pkg::MN_ECALL,
         rvd_pkg::MN_EBREAK: begin
            ua = 1'b0; ub = 1'b0; ud = 1'b0;
         end
         default: ;
      endcase
      if (!ok) begin
         id = rvd_pkg::MN_BEQ;
         ua = 1'b0; ub = 1'b0; ud = 1'b0;
         imm = '0;
      end
   end

   assign cls_stall = valid_ff && rsp_stall;
   assign take      = cls_valid && !cls_stall;
   assign valid_in  = take ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (take) begin
         id_ff  <= id;
         ra_ff  <= ua ? rs1 : 5'd0;
         rb_ff  <= ub ? rs2 : 5'd0;
         rd_ff  <= ud ? rd : 5'd0;
         ua_ff  <= ua;
         ub_ff  <= ub;
         ud_ff  <= ud;
         imm_ff <= imm;
         ok_ff  <= ok;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_mnemonic_id = id_ff;
   assign rsp_src_reg_a   = ra_ff;
   assign rsp_src_reg_b   = rb_ff;
   assign rsp_dest_reg    = rd_ff;
   assign rsp_uses_src_a  = ua_ff;
   assign rsp_uses_src_b  = ub_ff;
   assign rsp_uses_dest   = ud_ff;
   assign rsp_immediate   = imm_ff;
   assign rsp_recognized  = ok_ff;

   `RVD_ASSERT_IMP(a_b_unrec, clock, reset, valid_ff && !ok_ff,
      id_ff == rvd_pkg::MN_BEQ && !ua_ff && !ub_ff && !ud_ff && imm_ff == 32'd0,
      "unrecognised response not cleared")
   `RVD_ASSERT_IMP(a_b_rega, clock, reset, valid_ff && !ua_ff, ra_ff == 5'd0,
      "unused source a not zero")
   `RVD_ASSERT_NEXT(a_b_hold, clock, reset, valid_ff && rsp_stall, valid_ff,
      "stalled response dropped")
endmodule

>>> hdl/rv32im_instruction_decoder.sv
// Top level of the RV32IM instruction decoder
`timescale 1ns / 1ps
// RV32IM instruction decoder.
// Request channel (req_): raw instruction word plus its pc, valid/stall
// handshake; a request is taken at a clock edge with req_valid high and
// req_stall low.
// Response channel (rsp_): mnemonic id (base or preferred alias), register
// operands with usage flags, immediate (or branch/jump target, upper field,
// shamt) and a recognised flag; unrecognised words give all-zero fields.
// Front end registers the request and the first-hit table match; a two-entry
// queue decouples it from the back end, which chooses aliases, builds the
// immediate and target, and holds the response register.
// Path: an accepted request is registered in the front end, then queued,
// then captured in the response register that drives rsp_valid.
// Throughput: one request per cycle, sustained while rsp_stall stays low;
// the table match is combinational, with separate branch and jump adders.
// Reset (synchronous, active high) empties every stage; no state otherwise.
// A stalled receiver holds the response steady; the queue and front register
// fill, after which req_stall rises. Nothing is dropped or repeated.
module rv32im_instruction_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_instr_word,
   input  logic [31:0]        req_pc,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [6:0]         rsp_mnemonic_id,
   output logic [4:0]         rsp_src_reg_a,
   output logic [4:0]         rsp_src_reg_b,
   output logic [4:0]         rsp_dest_reg,
   output logic               rsp_uses_src_a,
   output logic               rsp_uses_src_b,
   output logic               rsp_uses_dest,
   output logic signed [31:0] rsp_immediate,
   output logic               rsp_recognized
);
   rvd_pkg::classified_type f_data, q_data;
   logic f_valid, f_stall, q_valid, q_stall;

   rvd_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_instr_word, .req_pc,
      .cls_valid(f_valid), .cls_stall(f_stall), .cls_data(f_data)
   );

   rvd_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   rvd_back u_back (
      .clock, .reset,
      .cls_valid(q_valid), .cls_stall(q_stall), .cls_data(q_data),
      .rsp_valid, .rsp_stall, .rsp_mnemonic_id, .rsp_src_reg_a, .rsp_src_reg_b,
      .rsp_dest_reg, .rsp_uses_src_a, .rsp_uses_src_b, .rsp_uses_dest,
      .rsp_immediate, .rsp_recognized
   );
endmodule

>>> verif/testbench.sv
// Self-checking testbench for the RV32IM instruction decoder
`timescale 1ns / 1ps
module testbench;
   // one decoded response as the block should present it
   typedef struct {
      logic [6:0]  mnemonic_id;
      logic [4:0]  src_reg_a;
      logic [4:0]  src_reg_b;
      logic [4:0]  dest_reg;
      logic        uses_src_a;
      logic        uses_src_b;
      logic        uses_dest;
      logic [31:0] immediate;
      logic        recognized;
   } decoded_type;

   // first-hit match over the RV32IM encodings, table order
   function automatic int match_index(input logic [31:0] w);
      logic [6:0]  opc;
      logic [2:0]  f3;
      logic [6:0]  f7;
      opc = w[6:0];
      f3  = w[14:12];
      f7  = w[31:25];
      case (opc)
         7'h63: begin
            case (f3)
               3'd0: return rvd_pkg::MN_BEQ;
               3'd1: return rvd_pkg::MN_BNE;
               3'd4: return rvd_pkg::MN_BLT;
               3'd5: return rvd_pkg::MN_BGE;
               3'd6: return rvd_pkg::MN_BLTU;
               3'd7: return rvd_pkg::MN_BGEU;
               default: return -1;
            endcase
         end
         7'h67: return (f3 == 3'd0) ? rvd_pkg::MN_JALR : -1;
         7'h6f: return rvd_pkg::MN_JAL;
         7'h37: return rvd_pkg::MN_LUI;
         7'h17: return rvd_pkg::MN_AUIPC;
         7'h13: begin
            case (f3)
               3'd0: return rvd_pkg::MN_ADDI;
               3'd1: return (f7 == 7'h00) ? rvd_pkg::MN_SLLI : -1;
               3'd2: return rvd_pkg::MN_SLTI;
               3'd3: return rvd_pkg::MN_SLTIU;
               3'd4: return rvd_pkg::MN_XORI;
               3'd5: return (f7 == 7'h00) ? rvd_pkg::MN_SRLI :
                            (f7 == 7'h20) ? rvd_pkg::MN_SRAI : -1;
               3'd6: return rvd_pkg::MN_ORI;
               default: return rvd_pkg::MN_ANDI;
            endcase
         end
         7'h33: begin
            if (f7 == 7'h01) return rvd_pkg::MN_MUL + f3;
            if (f7 == 7'h20) return (f3 == 3'd0) ? rvd_pkg::MN_SUB :
                                    (f3 == 3'd5) ? rvd_pkg::MN_SRA : -1;
            if (f7 != 7'h00) return -1;
            case (f3)
               3'd0: return rvd_pkg::MN_ADD;
               3'd1: return rvd_pkg::MN_SLL;
               3'd2: return rvd_pkg::MN_SLT;
               3'd3: return rvd_pkg::MN_SLTU;
               3'd4: return rvd_pkg::MN_XOR;
               3'd5: return rvd_pkg::MN_SRL;
               3'd6: return rvd_pkg::MN_OR;
               default: return rvd_pkg::MN_AND;
            endcase
         end
         7'h03: begin
            case (f3)
               3'd0: return rvd_pkg::MN_LB;
               3'd1: return rvd_pkg::MN_LH;
               3'd2: return rvd_pkg::MN_LW;
               3'd4: return rvd_pkg::MN_LBU;
               3'd5: return rvd_pkg::MN_LHU;
               default: return -1;
            endcase
         end
         7'h23: return (f3 <= 3'd2) ? rvd_pkg::MN_SB + f3 : -1;
         7'h0f: return (f3 == 3'd0) ? rvd_pkg::MN_FENCE :
                       (f3 == 3'd1) ? rvd_pkg::MN_FENCEI : -1;
         7'h73: return (w == 32'h73) ? rvd_pkg::MN_ECALL :
                       (w == 32'h100073) ? rvd_pkg::MN_EBREAK : -1;
         default: return -1;
      endcase
   endfunction

   function automatic decoded_type fill(input logic [31:0] w, input int id,
      input int ua, input int ub, input int ud, input logic [31:0] imm);
      decoded_type d;
      d.mnemonic_id = 7'(id);
      d.uses_src_a  = (ua != 0);
      d.uses_src_b  = (ub != 0);
      d.uses_dest   = (ud != 0);
      d.src_reg_a   = (ua != 0) ? w[19:15] : 5'd0;
      d.src_reg_b   = (ub != 0) ? w[24:20] : 5'd0;
      d.dest_reg    = (ud != 0) ? w[11:7] : 5'd0;
      d.immediate   = imm;
      d.recognized  = 1'b1;
      return d;
   endfunction

   function automatic decoded_type decode_word(input logic [31:0] w, input logic [31:0] pc);
      decoded_type d;
      int          id;
      logic [4:0]  rs1, rs2, rd;
      logic [31:0] ii, is, ib, ij, tb;
      rs1 = w[19:15];
      rs2 = w[24:20];
      rd  = w[11:7];
      ii  = {{20{w[31]}}, w[31:20]};
      is  = {{20{w[31]}}, w[31:25], w[11:7]};
      ib  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      ij  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      tb  = pc + ib;
      d   = '{default: '0};
      id  = match_index(w);
      if (id < 0) return d;
      case (id)
         rvd_pkg::MN_BEQ: d = (rs2 == 0) ? fill(w, rvd_pkg::MN_BEQZ, 1, 0, 0, tb)
                                         : fill(w, id, 1, 1, 0, tb);
         rvd_pkg::MN_BNE: d = (rs2 == 0) ? fill(w, rvd_pkg::MN_BNEZ, 1, 0, 0, tb)
                                         : fill(w, id, 1, 1, 0, tb);
         rvd_pkg::MN_BLT: d = (rs2 == 0) ? fill(w, rvd_pkg::MN_BLTZ, 1, 0, 0, tb) :
                              (rs1 == 0) ? fill(w, rvd_pkg::MN_BGTZ, 0, 1, 0, tb) :
                                           fill(w, id, 1, 1, 0, tb);
         rvd_pkg::MN_BGE: d = (rs2 == 0) ? fill(w, rvd_pkg::MN_BGEZ, 1, 0, 0, tb) :
                              (rs1 == 0) ? fill(w, rvd_pkg::MN_BLEZ, 0, 1, 0, tb) :
                                           fill(w, id, 1, 1, 0, tb);
         rvd_pkg::MN_BLTU, rvd_pkg::MN_BGEU: d = fill(w, id, 1, 1, 0, tb);
         rvd_pkg::MN_JALR: begin
            if (ii == 0 && rd == 0 && rs1 == 1) d = fill(w, rvd_pkg::MN_RET, 0, 0, 0, 0);
            else if (ii == 0 && rd == 1) d = fill(w, rvd_pkg::MN_JALR, 1, 0, 0, 0);
            else if (ii == 0 && rd == 0) d = fill(w, rvd_pkg::MN_JR, 1, 0, 0, 0);
            else if (rd == rs1) d = fill(w, rvd_pkg::MN_JALR, 1, 0, 0, ii);
            else d = fill(w, rvd_pkg::MN_JALR, 1, 0, 1, ii);
         end
         rvd_pkg::MN_JAL: d = (rd == 0) ? fill(w, rvd_pkg::MN_J, 0, 0, 0, pc + ij)
                                        : fill(w, id, 0, 0, 1, pc + ij);
         rvd_pkg::MN_LUI, rvd_pkg::MN_AUIPC: d = fill(w, id, 0, 0, 1, {12'd0, w[31:12]});
         rvd_pkg::MN_ADDI: begin
            if (rs1 == 0) d = (rd == 0 && ii == 0) ? fill(w, rvd_pkg::MN_NOP, 0, 0, 0, 0)
                                                    : fill(w, rvd_pkg::MN_LI, 0, 0, 1, ii);
            else if (ii == 0) d = fill(w, rvd_pkg::MN_MV, 1, 0, 1, 0);
            else d = fill(w, id, 1, 0, 1, ii);
         end
         rvd_pkg::MN_SLLI, rvd_pkg::MN_SRLI, rvd_pkg::MN_SRAI:
            d = fill(w, id, 1, 0, 1, {27'd0, rs2});
         rvd_pkg::MN_SLTIU: d = (ii == 1) ? fill(w, rvd_pkg::MN_SEQZ, 1, 0, 1, 0)
                                          : fill(w, id, 1, 0, 1, ii);
         rvd_pkg::MN_XORI: d = (ii == '1) ? fill(w, rvd_pkg::MN_NOT, 1, 0, 1, 0)
                                          : fill(w, id, 1, 0, 1, ii);
         rvd_pkg::MN_SLTI, rvd_pkg::MN_ORI, rvd_pkg::MN_ANDI, rvd_pkg::MN_LB,
         rvd_pkg::MN_LH, rvd_pkg::MN_LW, rvd_pkg::MN_LBU, rvd_pkg::MN_LHU:
            d = fill(w, id, 1, 0, 1, ii);
         rvd_pkg::MN_SUB: d = (rs1 == 0) ? fill(w, rvd_pkg::MN_NEG, 0, 1, 1, 0)
                                         : fill(w, id, 1, 1, 1, 0);
         rvd_pkg::MN_SLT: d = (rs1 == 0) ? fill(w, rvd_pkg::MN_SGTZ, 0, 1, 1, 0)
                                         : fill(w, id, 1, 1, 1, 0);
         rvd_pkg::MN_SLTU: d = (rs1 == 0) ? fill(w, rvd_pkg::MN_SNEZ, 0, 1, 1, 0)
                                          : fill(w, id, 1, 1, 1, 0);
         rvd_pkg::MN_SB, rvd_pkg::MN_SH, rvd_pkg::MN_SW: d = fill(w, id, 1, 1, 0, is);
         rvd_pkg::MN_FENCE, rvd_pkg::MN_FENCEI, rvd_pkg::MN_ECALL, rvd_pkg::MN_EBREAK:
            d = fill(w, id, 0, 0, 0, 0);
         default: d = fill(w, id, 1, 1, 1, 0);
      endcase
      return d;
   endfunction

   // in-order store of pending decodes, checked against each response
   class decode_scoreboard;
      decoded_type pending[$];
      int          errors;

      function void note_request(input logic [31:0] w, input logic [31:0] pc);
         pending.push_back(decode_word(w, pc));
      endfunction

      function void check_response(input decoded_type got);
         decoded_type want;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.mnemonic_id !== want.mnemonic_id) begin
            $error("mnemonic_id exp %0d got %0d", want.mnemonic_id, got.mnemonic_id);
            errors++;
         end
         if (got.src_reg_a !== want.src_reg_a) begin
            $error("src_reg_a exp %0d got %0d", want.src_reg_a, got.src_reg_a);
            errors++;
         end
         if (got.src_reg_b !== want.src_reg_b) begin
            $error("src_reg_b exp %0d got %0d", want.src_reg_b, got.src_reg_b);
            errors++;
         end
         if (got.dest_reg !== want.dest_reg) begin
            $error("dest_reg exp %0d got %0d", want.dest_reg, got.dest_reg);
            errors++;
         end
         if (got.uses_src_a !== want.uses_src_a) begin
            $error("uses_src_a exp %0b got %0b", want.uses_src_a, got.uses_src_a);
            errors++;
         end
         if (got.uses_src_b !== want.uses_src_b) begin
            $error("uses_src_b exp %0b got %0b", want.uses_src_b, got.uses_src_b);
            errors++;
         end
         if (got.uses_dest !== want.uses_dest) begin
            $error("uses_dest exp %0b got %0b", want.uses_dest, got.uses_dest);
            errors++;
         end
         if (got.immediate !== want.immediate) begin
            $error("immediate exp %h got %h", want.immediate, got.immediate);
            errors++;
         end
         if (got.recognized !== want.recognized) begin
            $error("recognized exp %0b got %0b", want.recognized, got.recognized);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [31:0]        req_instr_word;
   logic [31:0]        req_pc;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [6:0]         rsp_mnemonic_id;
   logic [4:0]         rsp_src_reg_a;
   logic [4:0]         rsp_src_reg_b;
   logic [4:0]         rsp_dest_reg;
   logic               rsp_uses_src_a;
   logic               rsp_uses_src_b;
   logic               rsp_uses_dest;
   logic signed [31:0] rsp_immediate;
   logic               rsp_recognized;

   decode_scoreboard   board;
   int unsigned        cycle_count;
   bit                 hold_off;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned RandomRequests = 1200;

   rv32im_instruction_decoder u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run guard; a hang anywhere ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("rv32im_instruction_decoder: mismatch");
         $finish;
      end
   end

   // note the request the block takes at this edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_request(req_instr_word, req_pc);
   end

   // check the response the block hands over at this edge
   always @(posedge clock) begin
      decoded_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.mnemonic_id = rsp_mnemonic_id;
         got.src_reg_a   = rsp_src_reg_a;
         got.src_reg_b   = rsp_src_reg_b;
         got.dest_reg    = rsp_dest_reg;
         got.uses_src_a  = rsp_uses_src_a;
         got.uses_src_b  = rsp_uses_src_b;
         got.uses_dest   = rsp_uses_dest;
         got.immediate   = rsp_immediate;
         got.recognized  = rsp_recognized;
         board.check_response(got);
      end
   end

   // receiver stall pattern: phases of none, light, heavy; one long hold-off
   always @(posedge clock) begin
      int unsigned phase;
      phase = (cycle_count / 300) % 3;
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_off)
         rsp_stall <= 1'b1;
      else if (phase == 0)
         rsp_stall <= 1'b0;
      else if (phase == 1)
         rsp_stall <= ($urandom_range(0, 3) == 0);
      else
         rsp_stall <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      hold_off = 1'b0;
      wait (cycle_count == 600);
      hold_off = 1'b1;
      repeat (60) @(posedge clock);
      hold_off <= 1'b0;
   end

   // offer one request and hold it until the block takes it
   task automatic send_request(input logic [31:0] w, input logic [31:0] pc);
      req_valid      <= 1'b1;
      req_instr_word <= w;
      req_pc         <= pc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_gap(input int unsigned n);
      if (n == 0) return;
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // well-formed word for an encoding row, with random operand fields
   function automatic logic [31:0] random_word(input int sel);
      rvd_pkg::pattern_type p;
      logic [31:0] w;
      p = rvd_pkg::pattern_at(sel[5:0]);
      w = $urandom();
      // bias register fields to x0/x1 now and then to reach the aliases
      if ($urandom_range(0, 2) == 0) w[19:15] = 5'($urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0) w[24:20] = 5'($urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0) w[11:7]  = 5'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) w[31:20] = $urandom_range(0, 1) ? 12'hfff : 12'h000;
      if ($urandom_range(0, 7) == 0) w[31:20] = 12'h001;
      if ($urandom_range(0, 7) == 0) w[11:7] = w[19:15];
      return (w & ~p.mask) | p.match;
   endfunction

   initial begin
      logic [31:0] w;
      int          n;
      board          = new();
      cycle_count    = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_instr_word = '0;
      req_pc         = '0;
      rsp_stall      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: aliases, extremes, shift funct7 faults, all-zero/all-one words
      send_request(32'h0000_0013, 32'h0);          // nop
      send_request(32'hfff0_0093, 32'h0);          // li -1
      send_request(32'h0000_8113, 32'h0);          // mv
      send_request(32'h0000_8067, 32'h0);          // ret
      send_request(32'h0002_80e7, 32'h0);          // jalr, rd x1, zero offset
      send_request(32'h0002_8067, 32'h0);          // jr
      send_request(32'h0042_8293, 32'h0);          // addi rd == rs1
      send_request(32'h0042_82e7, 32'h0);          // jalr rd == rs1, nonzero offset
      send_request(32'h0013_3513, 32'h0);          // seqz
      send_request(32'hfff5_4513, 32'h0);          // not
      send_request(32'h40b0_0533, 32'h0);          // neg
      send_request(32'h00b0_2533, 32'h0);          // sgtz
      send_request(32'h00b0_3533, 32'h0);          // snez
      send_request(32'h8000_006f, 32'hffff_fff0);  // j, negative, wraps
      send_request(32'h7fff_f0ef, 32'hffff_ff00);  // jal, wraps
      send_request(32'hfe05_0ee3, 32'h0000_0004);  // beqz, backward below zero
      send_request(32'h00a0_4063, 32'h0);          // bgtz
      send_request(32'h00a0_5063, 32'h0);          // blez
      send_request(32'h4010_1013, 32'h0);          // slli bad funct7
      send_request(32'h41f0_5013, 32'h0);          // srai shamt 31
      send_request(32'h0000_0073, 32'h0);          // ecall
      send_request(32'h0010_0073, 32'h0);          // ebreak
      send_request(32'hffff_ffff, 32'hffff_ffff);
      send_request(32'h0000_0000, 32'h0);
      send_request(32'hffff_f037, 32'h0);          // lui full upper field

      // random bursts: mostly valid encodings, some raw noise
      n = 0;
      while (n < RandomRequests) begin
         int unsigned burst;
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            if ($urandom_range(0, 9) == 0) w = $urandom();
            else w = random_word($urandom_range(0, rvd_pkg::NumPatterns - 1));
            send_request(w, $urandom());
            n++;
         end
         idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0)
         $display("rv32im_instruction_decoder: match");
      else
         $display("rv32im_instruction_decoder: mismatch");
      $finish;
   end
endmodule
